>>> hw/rtl/bsa_pkg.sv
package bsa_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int ENTRIES_W     = 9;
  localparam int COUNT_W       = 9;
  localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 9'd256;
  localparam int BIT_SEL_W     = 3;

  localparam logic [2:0] OP_FIND   = 3'd0;
  localparam logic [2:0] OP_FREE   = 3'd1;
  localparam logic [2:0] OP_CLAIM  = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] slot_index;
    logic [4:0] map_byte_index;
    logic [7:0] map_byte_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_index;
    logic               slot_is_free;
    logic [COUNT_W-1:0] free_total;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic scan;
    logic nospace;
  } dp_cmd_t;

  typedef struct packed {
    logic is_find;
    logic find_none;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

>>> hw/rtl/bsa_datapath.sv
module bsa_datapath #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::ENTRIES_W-1:0]  cfg_data,
  input  bsa_pkg::in_word_t              in_word,
  input  bsa_pkg::dp_cmd_t               cmd,
  output bsa_pkg::dp_stat_t              stat,
  output logic                           out_strobe,
  output bsa_pkg::out_word_t             out_word
);

  localparam int MAP_BYTES = (MAX_SLOTS + 7) / 8;
  localparam int MEM_BYTES = (MAP_BYTES < 32) ? MAP_BYTES : 32;
  localparam int AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int LW        = ($clog2(MAX_SLOTS + 1) > bsa_pkg::ENTRIES_W) ?
                             $clog2(MAX_SLOTS + 1) : bsa_pkg::ENTRIES_W;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  bsa_pkg::in_word_t                item_r;
  logic [bsa_pkg::ENTRIES_W-1:0]    entries_r;
  logic [bsa_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [7:0]                       map_r [MEM_BYTES];
  logic [7:0]                       rd_byte_r;
  logic [AW-1:0]                    ptr_r, ptr_nxt;
  bsa_pkg::out_word_t               res_r, res_nxt;
  logic                             strobe_r, strobe_nxt;

  logic                             wr_en;
  logic [7:0]                       wr_data;
  logic [AW-1:0]                    op_addr, rd_addr;
  logic                             bit_v, slot_ok, mbi_ok;
  logic [LW-1:0]                    ent_ext, lim, base, rem;
  logic [7:0]                       mask, hits;
  logic [bsa_pkg::BIT_SEL_W-1:0]    enc, pos;
  logic                             hit, last, is_find, find_none;

  // address and bit lookups
  always_comb begin
    pos     = item_r.slot_index[bsa_pkg::BIT_SEL_W-1:0];
    is_find = (item_r.operation == bsa_pkg::OP_FIND);
    if (item_r.operation == bsa_pkg::OP_LOAD) begin
      op_addr = item_r.map_byte_index[AW-1:0];
    end else begin
      op_addr = item_r.slot_index[AW+2:3];
    end
    bit_v   = rd_byte_r[pos];
    slot_ok = (LW'(item_r.slot_index) < LW'(MAX_SLOTS));
    mbi_ok  = (LW'(item_r.map_byte_index) < LW'(MAP_BYTES));
  end

  // find scan, one map byte per cycle
  always_comb begin
    ent_ext = LW'(entries_r);
    lim     = (ent_ext < LW'(MAX_SLOTS)) ? ent_ext : LW'(MAX_SLOTS);
    base    = LW'({ptr_r, 3'b000});
    rem     = lim - base;
    if (rem >= LW'(8)) begin
      mask = 8'hFF;
    end else begin
      mask = 8'((9'd1 << rem[2:0]) - 9'd1);
    end
    hits = rd_byte_r & mask;
    hit  = |hits;
    enc  = '0;
    for (int i = 7; i >= 0; i--) begin
      if (hits[i]) begin
        enc = bsa_pkg::BIT_SEL_W'(i);
      end
    end
    last      = (rem <= LW'(8)) || (ptr_r == AW'(MEM_BYTES - 1));
    find_none = (count_r == '0) || (lim == '0);
  end

  assign stat.is_find   = is_find;
  assign stat.find_none = find_none;
  assign stat.hit       = hit;
  assign stat.last      = last;

  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    res_nxt    = res_r;
    strobe_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_byte_r;
    if (cmd.take) begin
      ptr_nxt = '0;
    end
    if (cmd.nospace) begin
      res_nxt.status       = bsa_pkg::ST_NO_SPACE;
      res_nxt.found_index  = '0;
      res_nxt.slot_is_free = 1'b0;
      res_nxt.free_total   = count_r;
      strobe_nxt           = 1'b1;
    end
    if (cmd.scan) begin
      res_nxt.slot_is_free = 1'b0;
      res_nxt.free_total   = count_r;
      if (hit) begin
        res_nxt.status      = bsa_pkg::ST_OK;
        res_nxt.found_index = 8'({ptr_r, enc});
        strobe_nxt          = 1'b1;
      end else if (last) begin
        res_nxt.status      = bsa_pkg::ST_NO_SPACE;
        res_nxt.found_index = '0;
        strobe_nxt          = 1'b1;
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
    if (cmd.exec) begin
      res_nxt.status       = bsa_pkg::ST_OK;
      res_nxt.found_index  = '0;
      res_nxt.slot_is_free = 1'b0;
      case (item_r.operation)
        bsa_pkg::OP_FREE: begin
          if (!slot_ok || bit_v) begin
            res_nxt.status = bsa_pkg::ST_INVALID;
          end else begin
            wr_en     = 1'b1;
            wr_data   = rd_byte_r | (8'd1 << pos);
            count_nxt = count_r + 9'd1;
          end
        end
        bsa_pkg::OP_CLAIM: begin
          if (!slot_ok || !bit_v) begin
            res_nxt.status = bsa_pkg::ST_INVALID;
          end else begin
            wr_en     = 1'b1;
            wr_data   = rd_byte_r & ~(8'd1 << pos);
            count_nxt = count_r - 9'd1;
          end
        end
        bsa_pkg::OP_STATUS: begin
          if (!slot_ok) begin
            res_nxt.status = bsa_pkg::ST_INVALID;
          end else begin
            res_nxt.slot_is_free = bit_v;
          end
        end
        bsa_pkg::OP_LOAD: begin
          if (!mbi_ok) begin
            res_nxt.status = bsa_pkg::ST_INVALID;
          end else begin
            wr_en     = 1'b1;
            wr_data   = item_r.map_byte_value;
            count_nxt = count_r - 9'(ones8(rd_byte_r)) + 9'(ones8(item_r.map_byte_value));
          end
        end
        default: begin
          res_nxt.status = bsa_pkg::ST_INVALID;
        end
      endcase
      res_nxt.free_total = count_nxt;
      strobe_nxt         = 1'b1;
    end
  end

  // map byte wanted in the next cycle
  always_comb begin
    if (cmd.take) begin
      if (in_word.operation == bsa_pkg::OP_LOAD) begin
        rd_addr = in_word.map_byte_index[AW-1:0];
      end else begin
        rd_addr = in_word.slot_index[AW+2:3];
      end
    end else begin
      rd_addr = ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) begin
        map_r[i] <= '0;
      end
    end else if (wr_en) begin
      map_r[op_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= bsa_pkg::ENTRIES_RST;
      count_r   <= '0;
      ptr_r     <= '0;
      strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_r <= cfg_data;
      end
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_word;
    end
    rd_byte_r <= map_r[rd_addr];
    res_r     <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_word   = res_r;

endmodule

>>> hw/rtl/bsa_ctrl.sv
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bsa_pkg::dp_stat_t stat,
  output logic              busy,
  output bsa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.take    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.nospace = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.is_find) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.find_none) begin
          cmd.nospace = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hw/rtl/bitmap_slot_allocator_top.sv
// bitmap slot allocator: free map of slots, one bit per slot, 1 = free
// input channel: a word on in_word is taken at a clock edge with start high
//   and busy low; busy stays high while the word is worked on
// result channel: one word per input word, on out_word for one cycle with
//   out_strobe high; the receiver has no way to hold it off
// config channel: cfg_data sets the find range, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write only while idle
// free, claim, status and load run in the execute state, and the
//   result strobe comes in the cycle after it, when busy is already low, so a
//   new word can be taken in the same cycle as that strobe
// find runs the execute state and then scans one map byte per cycle through
//   a priority encoder, up to min(ceil(range/8), 32) bytes
// reset: map and free count clear (every slot used), the find range goes to
//   256, busy and out_strobe go low
module bitmap_slot_allocator_top #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bsa_pkg::in_word_t             in_word,
  output logic                          out_strobe,
  output bsa_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsa_pkg::ENTRIES_W-1:0] cfg_data
);

  bsa_pkg::dp_cmd_t  cmd;
  bsa_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .in_word    (in_word),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $fell(busy))
    else $error("result strobe without end of work");

  a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("work ended without result");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status != bsa_pkg::ST_OK)) |-> (out_word.found_index == 8'd0))
    else $error("found index on failed operation");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.free_total <=
      9'(8 * ((((MAX_SLOTS + 7) / 8) < 32) ? ((MAX_SLOTS + 7) / 8) : 32))))
    else $error("free count above map size");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    bsa_pkg::in_word_t  word;
    bit                 typed;
    bsa_pkg::out_word_t want;
  } alloc_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  bsa_pkg::in_word_t in_word = '0;
  logic out_strobe;
  bsa_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bsa_pkg::ENTRIES_W-1:0] cfg_data = '0;

  logic [7:0] slot_map [0:31];
  int unsigned free_slots = 0;
  int unsigned find_range = bsa_pkg::ENTRIES_RST;
  bsa_pkg::out_word_t pending_results[$];
  alloc_row_t dir_rows[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  bitmap_slot_allocator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < 32; i++) slot_map[i] = 8'h00;
  end

  function automatic bsa_pkg::out_word_t predict_alloc(bsa_pkg::in_word_t w);
    bsa_pkg::out_word_t r;
    int unsigned lim;
    r = '0;
    r.status = bsa_pkg::ST_OK;
    case (w.operation)
      bsa_pkg::OP_FIND: begin
        r.status = bsa_pkg::ST_NO_SPACE;
        if (free_slots != 0) begin
          lim = (find_range > bsa_pkg::MAX_SLOTS_DEF) ? bsa_pkg::MAX_SLOTS_DEF : find_range;
          for (int s = 0; s < lim; s++) begin
            if (slot_map[s / 8][s % 8]) begin
              r.status = bsa_pkg::ST_OK;
              r.found_index = 8'(s);
              break;
            end
          end
        end
      end
      bsa_pkg::OP_FREE: begin
        if (slot_map[w.slot_index[7:3]][w.slot_index[2:0]]) begin
          r.status = bsa_pkg::ST_INVALID;
        end else begin
          slot_map[w.slot_index[7:3]][w.slot_index[2:0]] = 1'b1;
          free_slots++;
        end
      end
      bsa_pkg::OP_CLAIM: begin
        if (!slot_map[w.slot_index[7:3]][w.slot_index[2:0]]) begin
          r.status = bsa_pkg::ST_INVALID;
        end else begin
          slot_map[w.slot_index[7:3]][w.slot_index[2:0]] = 1'b0;
          free_slots--;
        end
      end
      bsa_pkg::OP_STATUS: begin
        r.slot_is_free = slot_map[w.slot_index[7:3]][w.slot_index[2:0]];
      end
      bsa_pkg::OP_LOAD: begin
        free_slots = free_slots - $countones(slot_map[w.map_byte_index])
                     + $countones(w.map_byte_value);
        slot_map[w.map_byte_index] = w.map_byte_value;
      end
      default: begin
        r.status = bsa_pkg::ST_INVALID;
      end
    endcase
    r.free_total = (free_slots > 511) ? 9'd511 : 9'(free_slots);
    return r;
  endfunction

  function automatic bsa_pkg::in_word_t random_word();
    bsa_pkg::in_word_t w;
    int unsigned pick;
    w.slot_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    w.map_byte_index = 5'($urandom);
    case ($urandom_range(0, 5))
      0: w.map_byte_value = 8'h00;
      1: w.map_byte_value = 8'hFF;
      default: w.map_byte_value = 8'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) w.operation = bsa_pkg::OP_FIND;
    else if (pick < 48) w.operation = bsa_pkg::OP_FREE;
    else if (pick < 66) w.operation = bsa_pkg::OP_CLAIM;
    else if (pick < 80) w.operation = bsa_pkg::OP_STATUS;
    else if (pick < 92) w.operation = bsa_pkg::OP_LOAD;
    else w.operation = 3'($urandom_range(5, 7));
    return w;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] slot, logic [4:0] mbi,
                                  logic [7:0] mbv, bit typed, logic [1:0] st,
                                  logic [7:0] found, logic is_free, logic [8:0] total);
    alloc_row_t row;
    row.word = '{operation: op, slot_index: slot, map_byte_index: mbi, map_byte_value: mbv};
    row.typed = typed;
    row.want = '{status: st, found_index: found, slot_is_free: is_free, free_total: total};
    dir_rows.push_back(row);
  endfunction

  // leaves start high so a following word can go out back to back
  task automatic send_word(bsa_pkg::in_word_t w, bit typed, bsa_pkg::out_word_t want);
    bsa_pkg::out_word_t predicted;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predicted = predict_alloc(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(logic [bsa_pkg::ENTRIES_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    find_range = v;
  endtask

  task automatic run_random(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_word(random_word(), 1'b0, '0);
        left--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  // result check
  always @(posedge clk) begin
    bsa_pkg::out_word_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatch_count++;
        end
        if (out_word.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_word.found_index);
          mismatch_count++;
        end
        if (out_word.slot_is_free !== want.slot_is_free) begin
          $error("slot_is_free: expected %0d, got %0d", want.slot_is_free,
                 out_word.slot_is_free);
          mismatch_count++;
        end
        if (out_word.free_total !== want.free_total) begin
          $error("free_total: expected %0d, got %0d", want.free_total, out_word.free_total);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [bsa_pkg::ENTRIES_W-1:0] ranges [$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(bsa_pkg::OP_FIND, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_NO_SPACE, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_STATUS, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_CLAIM, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_FREE, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_FREE, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_FIND, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_FREE, 8'd255, 5'd31, 8'hFF, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd2);
    add_row(bsa_pkg::OP_CLAIM, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_FIND, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd255, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_STATUS, 8'd255, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b1, 9'd1);
    add_row(bsa_pkg::OP_LOAD, 8'd0, 5'd31, 8'hFF, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd8);
    add_row(bsa_pkg::OP_LOAD, 8'd255, 5'd0, 8'h80, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd9);
    add_row(bsa_pkg::OP_FIND, 8'd255, 5'd31, 8'hFF, 1, bsa_pkg::ST_OK, 8'd7, 1'b0, 9'd9);
    add_row(3'd5, 8'd255, 5'd31, 8'hFF, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd9);
    add_row(3'd6, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd9);
    add_row(3'd7, 8'd170, 5'd21, 8'h55, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd9);
    add_row(bsa_pkg::OP_LOAD, 8'd0, 5'd31, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd1);
    add_row(bsa_pkg::OP_LOAD, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_FIND, 8'd0, 5'd0, 8'h00, 1, bsa_pkg::ST_NO_SPACE, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_CLAIM, 8'd255, 5'd0, 8'h00, 1, bsa_pkg::ST_INVALID, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_LOAD, 8'd0, 5'd15, 8'h55, 0, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_STATUS, 8'd122, 5'd0, 8'h00, 0, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_FIND, 8'd0, 5'd0, 8'h00, 0, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_FREE, 8'd128, 5'd10, 8'hAA, 0, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);
    add_row(bsa_pkg::OP_CLAIM, 8'd122, 5'd0, 8'h00, 0, bsa_pkg::ST_OK, 8'd0, 1'b0, 9'd0);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(1, 6));
    end
    wait_idle();

    ranges = '{9'd1, 9'd0, 9'd511, 9'd8, 9'd257, 9'd256, 9'd100};
    ranges.push_back(9'($urandom_range(1, 256)));
    foreach (ranges[i]) begin
      write_range(ranges[i]);
      run_random(PHASE_ITEMS);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
